// ===== src/polynomial_mutation_core_macros.svh =====
// assertion macros shared by the polynomial mutation core
`ifndef POLYNOMIAL_MUTATION_CORE_MACROS_SVH
`define POLYNOMIAL_MUTATION_CORE_MACROS_SVH

// same-cycle implication
`define PM_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("pm check failed");

// next-cycle implication
`define PM_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("pm check failed");

`endif

// ===== src/pm_pkg.sv =====
// ----------------------------------------------------------------------------
// pm_pkg
// shared types and fixed-point constants of the polynomial mutation core
// ----------------------------------------------------------------------------
`default_nettype none
package pm_pkg;

	localparam int QB = 30;
	localparam int QW = QB + 1;
	localparam logic [QW-1:0] Q_ONE = QW'(1) << QB;
	localparam logic [15:0] PROB_RESET = 16'hFFFF;
	localparam logic [15:0] FRAC_MAX = 16'hFFFF;

	typedef struct packed {
		logic signed [31:0] y;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic [31:0] rng;
		logic down;
		logic mut;
		logic bad;
	} item_t;

	typedef struct packed {
		item_t it;
		logic [QW-1:0] r;
	} ir_t;

	typedef struct packed {
		item_t it;
		logic [QW-1:0] val;
		logic [QW-1:0] q;
	} rs_t;

endpackage
`default_nettype wire

// ===== src/pm_if.sv =====
// ----------------------------------------------------------------------------
// pm_if
// valid/ready channels of the polynomial mutation core
// ----------------------------------------------------------------------------
`default_nettype none
interface pm_item_if;
	logic valid;
	logic ready;
	logic signed [31:0] value_in;
	logic signed [31:0] lower_bound;
	logic signed [31:0] upper_bound;
	logic [15:0] rand_gate;
	logic [15:0] rand_shape;
	modport source (output valid, value_in, lower_bound, upper_bound, rand_gate, rand_shape,
		input ready);
	modport sink (input valid, value_in, lower_bound, upper_bound, rand_gate, rand_shape,
		output ready);
endinterface

interface pm_result_if;
	logic valid;
	logic ready;
	logic signed [31:0] value_out;
	logic was_mutated;
	logic bad_bounds;
	modport source (output valid, value_out, was_mutated, bad_bounds, input ready);
	modport sink (input valid, value_out, was_mutated, bad_bounds, output ready);
endinterface

interface pm_cfg_if;
	logic valid;
	logic ready;
	logic [15:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== src/pm_div.sv =====
// ----------------------------------------------------------------------------
// pm_div
// pipelined restoring divider, one quotient bit per stage: (d << QB) / rng
// ----------------------------------------------------------------------------
`default_nettype none
module pm_div #(
	parameter int SW = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic [31:0] in_d,
	input  wire logic [31:0] in_rng,
	input  wire logic [SW-1:0] in_side,
	output logic out_valid,
	output logic [pm_pkg::QW-1:0] out_quo,
	output logic [SW-1:0] out_side
);
	import pm_pkg::*;

	logic vld_s [QW+1];
	logic [32:0] rem_s [QW+1];
	logic [31:0] rng_s [QW+1];
	logic [QW-1:0] quo_s [QW+1];
	logic [SW-1:0] side_s [QW+1];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = {1'b0, in_d};
	assign rng_s[0] = in_rng;
	assign quo_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic ge;
		logic [32:0] rem_n;
		assign ge = rem_s[k] >= {1'b0, rng_s[k]};
		assign rem_n = ge ? rem_s[k] - {1'b0, rng_s[k]} : rem_s[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= {rem_n[31:0], 1'b0};
				rng_s[k+1] <= rng_s[k];
				quo_s[k+1] <= {quo_s[k][QW-2:0], ge};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign out_quo = quo_s[QW];
	assign out_side = side_s[QW];
endmodule
`default_nettype wire

// ===== src/pm_pow.sv =====
// ----------------------------------------------------------------------------
// pm_pow
// pipelined power x^N in Q30, one truncating multiply per stage
// ----------------------------------------------------------------------------
`default_nettype none
module pm_pow #(
	parameter int N = 51,
	parameter int SW = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic [pm_pkg::QW-1:0] in_x,
	input  wire logic [SW-1:0] in_side,
	output logic out_valid,
	output logic [pm_pkg::QW-1:0] out_p,
	output logic [pm_pkg::QW-1:0] out_x,
	output logic [SW-1:0] out_side
);
	import pm_pkg::*;

	logic vld_s [N+1];
	logic [QW-1:0] p_s [N+1];
	logic [QW-1:0] x_s [N+1];
	logic [SW-1:0] side_s [N+1];

	assign vld_s[0] = in_valid;
	assign p_s[0] = Q_ONE;
	assign x_s[0] = in_x;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [2*QW-1:0] prod;
		assign prod = {{QW{1'b0}}, p_s[k]} * {{QW{1'b0}}, x_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				p_s[k+1] <= prod[QB+QW-1:QB];
				x_s[k+1] <= x_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_p = p_s[N];
	assign out_x = x_s[N];
	assign out_side = side_s[N];
endmodule
`default_nettype wire

// ===== src/polynomial_mutation_core.sv =====
// ----------------------------------------------------------------------------
// polynomial_mutation_core
// Takes one word per clock while not stalled, returns one result word per
// item, in order. A 31-stage divider normalises the bound distance, a
// chain of DIST_INDEX+1 multiply stages forms the power, and the root is a
// bit-by-bit search over 31 bits, each bit its own power chain and compare.
// Every stage holds while the result register waits to be taken.
// DIST_INDEX defaults to 50.
// ----------------------------------------------------------------------------
`default_nettype none
`include "polynomial_mutation_core_macros.svh"
module polynomial_mutation_core #(
	parameter int DIST_INDEX = 50
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pm_item_if.sink item,
	pm_result_if.source result,
	pm_cfg_if.sink cfg
);
	import pm_pkg::*;

	localparam int NPOW = DIST_INDEX + 1;

	logic en;
	logic [15:0] prob_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prob_q <= PROB_RESET;
		end else if (cfg.valid) begin
			prob_q <= cfg.data;
		end
	end

	// entry stage
	logic signed [32:0] rng_w, dist_w;
	logic [29:0] sh_w;
	logic [16:0] rem_w;
	logic [13:0] q0_w;
	logic [QW-1:0] r_w;
	logic [31:0] d_w;
	item_t it_w;
	logic vld_s1;
	ir_t ir_s1;
	logic [31:0] d_s1;

	always_comb begin
		rng_w = 33'(item.upper_bound) - 33'(item.lower_bound);
		sh_w = {item.rand_shape, 14'd0};
		q0_w = sh_w[29:16];
		rem_w = {1'b0, sh_w[15:0]} + {3'd0, q0_w};
		r_w = {1'b0, sh_w} + QW'(q0_w) + QW'(rem_w >= {1'b0, FRAC_MAX});
		it_w.y = item.value_in;
		it_w.lo = item.lower_bound;
		it_w.hi = item.upper_bound;
		it_w.rng = rng_w[31:0];
		it_w.down = !item.rand_shape[15];
		it_w.bad = rng_w <= 0;
		it_w.mut = !it_w.bad && (item.rand_gate <= prob_q);
		dist_w = it_w.down ? 33'(item.value_in) - 33'(item.lower_bound)
			: 33'(item.upper_bound) - 33'(item.value_in);
		if (dist_w < 0) begin
			d_w = '0;
		end else if (dist_w > rng_w) begin
			d_w = rng_w[31:0];
		end else begin
			d_w = dist_w[31:0];
		end
	end

	assign item.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ir_s1 <= '{it: it_w, r: r_w};
			d_s1 <= d_w;
		end
	end

	// normalised distance
	logic div_v;
	logic [QW-1:0] delta;
	logic [$bits(ir_t)-1:0] div_side;

	pm_div #(.SW($bits(ir_t))) u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s1), .in_d(d_s1), .in_rng(ir_s1.it.rng), .in_side(ir_s1),
		.out_valid(div_v), .out_quo(delta), .out_side(div_side)
	);

	// (1 - delta)^(n+1)
	logic pw_v;
	logic [QW-1:0] pw, pw_x;
	logic [$bits(ir_t)-1:0] pw_side;

	pm_pow #(.N(NPOW), .SW($bits(ir_t))) u_pow (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(div_v), .in_x(Q_ONE - delta), .in_side(div_side),
		.out_valid(pw_v), .out_p(pw), .out_x(pw_x), .out_side(pw_side)
	);

	// blend
	ir_t pir;
	logic [31:0] r2;
	logic [QW-1:0] fa, fb;
	assign pir = ir_t'(pw_side);
	assign r2 = {pir.r, 1'b0};
	always_comb begin
		if (pir.it.down) begin
			fa = QW'({1'b0, Q_ONE} - r2);
			fb = r2[QW-1:0];
		end else begin
			fa = QW'(r2 - {1'b0, Q_ONE});
			fb = QW'({Q_ONE, 1'b0} - r2);
		end
	end

	logic va_s2, vb_s3;
	logic [2*QW-1:0] m_s2;
	logic [QW-1:0] base_s2;
	item_t it_s2;
	rs_t rs_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_s2 <= 1'b0;
			vb_s3 <= 1'b0;
		end else if (en) begin
			va_s2 <= pw_v;
			vb_s3 <= va_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2 <= {{QW{1'b0}}, fa} * {{QW{1'b0}}, pw};
			base_s2 <= fb;
			it_s2 <= pir.it;
			rs_s3 <= '{it: it_s2, val: base_s2 + m_s2[QB+QW-1:QB], q: '0};
		end
	end

	// root search, one bit per power chain
	logic rv [QW+1];
	rs_t rside [QW+1];
	assign rv[0] = vb_s3;
	assign rside[0] = rs_s3;

	for (genvar k = 0; k < QW; k++) begin : g_root
		localparam int B = QB - k;
		logic [QW-1:0] c;
		logic cv;
		logic [QW-1:0] cp, cx;
		logic [$bits(rs_t)-1:0] cs;
		rs_t crs;
		logic take;

		assign c = rside[k].q | (QW'(1) << B);

		pm_pow #(.N(NPOW), .SW($bits(rs_t))) u_rpow (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(rv[k]), .in_x(c), .in_side(rside[k]),
			.out_valid(cv), .out_p(cp), .out_x(cx), .out_side(cs)
		);

		assign crs = rs_t'(cs);
		assign take = ((B == QB) || !crs.q[QB]) && (cp <= crs.val);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv[k+1] <= 1'b0;
			end else if (en) begin
				rv[k+1] <= cv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rside[k+1] <= '{it: crs.it, val: crs.val, q: take ? cx : crs.q};
			end
		end
	end

	// shift and clamp
	logic vs_s4;
	logic [2*QW+1:0] sp_s4;
	item_t it_s4;
	rs_t rf;
	assign rf = rside[QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vs_s4 <= 1'b0;
		end else if (en) begin
			vs_s4 <= rv[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s4 <= {{(QW+1){1'b0}}, Q_ONE - rf.q} * {{QW{1'b0}}, 1'b0, rf.it.rng};
			it_s4 <= rf.it;
		end
	end

	logic [32:0] shift;
	logic signed [34:0] sum;
	logic signed [31:0] res;
	assign shift = sp_s4[QB+32:QB];
	always_comb begin
		sum = it_s4.down ? 35'(it_s4.y) - 35'(shift) : 35'(it_s4.y) + 35'(shift);
		if (!it_s4.mut) begin
			res = it_s4.y;
		end else if (sum < 35'(it_s4.lo)) begin
			res = it_s4.lo;
		end else if (sum > 35'(it_s4.hi)) begin
			res = it_s4.hi;
		end else begin
			res = sum[31:0];
		end
	end

	logic vo_q;
	item_t it_o;
	assign en = !vo_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (en) begin
			vo_q <= vs_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result.value_out <= res;
			result.was_mutated <= it_s4.mut;
			result.bad_bounds <= it_s4.bad;
			it_o <= it_s4;
		end
	end

	assign result.valid = vo_q;

	`PM_ASSERT_IMP(a_flags_excl, vo_q, !(result.was_mutated && result.bad_bounds))
	`PM_ASSERT_IMP(a_in_bounds, vo_q && result.was_mutated,
		(result.value_out >= it_o.lo) && (result.value_out <= it_o.hi))
	`PM_ASSERT_IMP(a_stall_blocks, vo_q && !result.ready, !item.ready)
	`PM_ASSERT_NXT(a_cfg_write, cfg.valid, prob_q == $past(cfg.data))
endmodule
`default_nettype wire

// ===== tb/sv/polynomial_mutation_core_checker.sv =====
// ----------------------------------------------------------------------------
// polynomial_mutation_core_checker
// Watches the item, result and configuration channels of the polynomial
// mutation core, predicts each result word with a fixed-point model of its
// own and compares the words in order, counting every failure.
// ----------------------------------------------------------------------------
`default_nettype none
module polynomial_mutation_core_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	pm_item_if.sink item,
	pm_result_if.sink result,
	pm_cfg_if.sink cfg,
	output int n_errors,
	output int n_pending
);
	import pm_pkg::*;

	localparam int N_EXP = 51;
	localparam logic [63:0] ONE = 64'd1 << 30;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic was_mutated;
		logic bad_bounds;
	} mut_word_t;

	mut_word_t mutated_q[$];
	logic [15:0] gate_thresh;

	function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
		fx_mul = (a * b) >> 30;
	endfunction

	function automatic logic [63:0] fx_pow(input logic [63:0] x);
		logic [63:0] p;
		p = ONE;
		for (int i = 0; i < N_EXP; i++)
			p = fx_mul(p, x);
		fx_pow = p;
	endfunction

	function automatic logic [63:0] fx_root(input logic [63:0] v);
		logic [63:0] q;
		logic [63:0] c;
		q = 0;
		for (int b = 30; b >= 0; b--) begin
			c = q | (64'd1 << b);
			if (c <= ONE && fx_pow(c) <= v)
				q = c;
		end
		fx_root = q;
	endfunction

	function automatic mut_word_t mutate_var(input logic signed [31:0] y,
			input logic signed [31:0] lo, input logic signed [31:0] hi,
			input logic [15:0] gate, input logic [15:0] shape);
		mut_word_t w;
		logic signed [63:0] y64, lo64, hi64, d, res;
		logic [63:0] rng, r, dn, pw, v, sh;
		logic down;
		y64 = y;
		lo64 = lo;
		hi64 = hi;
		w.value_out = y;
		w.was_mutated = 1'b0;
		w.bad_bounds = 1'b0;
		if (hi64 <= lo64) begin
			w.bad_bounds = 1'b1;
		end else if (gate <= gate_thresh) begin
			rng = hi64 - lo64;
			r = ({48'd0, shape} << 30) / 64'd65535;
			down = shape <= 16'd32767;
			d = down ? y64 - lo64 : hi64 - y64;
			if (d < 0)
				d = 0;
			if (d > $signed(rng))
				d = rng;
			dn = (64'(d) << 30) / rng;
			pw = fx_pow(ONE - dn);
			if (down)
				v = 2 * r + fx_mul(ONE - 2 * r, pw);
			else
				v = 2 * (ONE - r) + fx_mul(2 * r - ONE, pw);
			sh = ((ONE - fx_root(v)) * rng) >> 30;
			res = down ? y64 - $signed(sh) : y64 + $signed(sh);
			if (res < lo64)
				res = lo64;
			if (res > hi64)
				res = hi64;
			w.value_out = res[31:0];
			w.was_mutated = 1'b1;
		end
		mutate_var = w;
	endfunction

	assign n_pending = mutated_q.size();

	always @(posedge clk or negedge arst_n) begin
		mut_word_t e;
		int errs;
		errs = 0;
		if (!arst_n) begin
			gate_thresh <= PROB_RESET;
			n_errors <= 0;
			mutated_q.delete();
		end else begin
			if (cfg.valid && cfg.ready)
				gate_thresh <= cfg.data;
			if (item.valid && item.ready)
				mutated_q.push_back(mutate_var(item.value_in, item.lower_bound,
					item.upper_bound, item.rand_gate, item.rand_shape));
			if (result.valid && result.ready) begin
				if (mutated_q.size() == 0) begin
					$error("unexpected result word");
					errs++;
				end else begin
					e = mutated_q.pop_front();
					if (e.value_out !== result.value_out) begin
						$error("value_out: expected %0d, got %0d", e.value_out, result.value_out);
						errs++;
					end
					if (e.was_mutated !== result.was_mutated) begin
						$error("was_mutated: expected %0b, got %0b", e.was_mutated,
							result.was_mutated);
						errs++;
					end
					if (e.bad_bounds !== result.bad_bounds) begin
						$error("bad_bounds: expected %0b, got %0b", e.bad_bounds,
							result.bad_bounds);
						errs++;
					end
				end
			end
			if (errs != 0)
				n_errors <= n_errors + errs;
		end
	end
endmodule
`default_nettype wire

// ===== tb/sv/polynomial_mutation_core_tb.sv =====
// ----------------------------------------------------------------------------
// polynomial_mutation_core_tb
// Drives variables with bounds and random fractions into the polynomial
// mutation core under several idling patterns and mutation probabilities;
// the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
`default_nettype none
module polynomial_mutation_core_tb;
	logic clk;
	logic arst_n;
	int n_errors;
	int n_pending;
	int src_idle;
	int snk_stall;

	pm_item_if item_ch();
	pm_result_if result_ch();
	pm_cfg_if cfg_ch();

	polynomial_mutation_core DUT (
		.clk(clk), .arst_n(arst_n), .item(item_ch.sink),
		.result(result_ch.source), .cfg(cfg_ch.sink)
	);

	polynomial_mutation_core_checker checker_i (
		.clk(clk), .arst_n(arst_n), .item(item_ch.sink),
		.result(result_ch.sink), .cfg(cfg_ch.sink),
		.n_errors(n_errors), .n_pending(n_pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("polynomial_mutation_core_tb: done, errors");
		$finish;
	end

	always @(posedge clk)
		result_ch.ready <= ($urandom_range(99) >= snk_stall);

	task automatic send_var(input logic [31:0] y, input logic [31:0] lo,
			input logic [31:0] hi, input logic [15:0] g, input logic [15:0] s);
		while ($urandom_range(99) < src_idle) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.value_in <= y;
		item_ch.lower_bound <= lo;
		item_ch.upper_bound <= hi;
		item_ch.rand_gate <= g;
		item_ch.rand_shape <= s;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
	endtask

	task automatic set_prob(input logic [15:0] p);
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (n_pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= p;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_rand();
		logic [31:0] lo, hi, y, span;
		int k;
		k = $urandom_range(9);
		lo = $urandom;
		span = (k < 7) ? ($urandom >> $urandom_range(31)) : $urandom;
		hi = (k == 9) ? lo - $urandom_range(3) : lo + span;
		if ($signed(hi) <= $signed(lo) && k < 9)
			hi = lo + 1;
		y = (k == 8) ? $urandom : lo + ($urandom % (span + 1));
		send_var(y, lo, hi, $urandom, $urandom);
	endtask

	initial begin
		logic [15:0] probs[5];
		probs = '{16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'hC000};
		arst_n = 1'b0;
		src_idle = 0;
		snk_stall = 0;
		item_ch.valid = 1'b0;
		item_ch.value_in = '0;
		item_ch.lower_bound = '0;
		item_ch.upper_bound = '0;
		item_ch.rand_gate = '0;
		item_ch.rand_shape = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_var(32'h0001_0000, 32'h0000_0000, 32'h000A_0000, 16'h0000, 16'h0000);
		send_var(32'h0001_0000, 32'h0000_0000, 32'h000A_0000, 16'hFFFF, 16'hFFFF);
		send_var(32'h0005_0000, 32'h0000_0000, 32'h000A_0000, 16'h1234, 16'h7FFF);
		send_var(32'h0005_0000, 32'h0000_0000, 32'h000A_0000, 16'h1234, 16'h8000);
		send_var(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 16'h0000);
		send_var(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 16'hFFFF);
		send_var(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 16'hFFFF);
		send_var(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 16'h0000);
		send_var(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 16'h0000, 16'h0000);
		send_var(32'h1234_5678, 32'h0002_0000, 32'h0001_0000, 16'h0000, 16'hFFFF);
		send_var(32'hFFF0_0000, 32'h0000_0000, 32'h0001_0000, 16'h0000, 16'h0000);
		send_var(32'h0010_0000, 32'h0000_0000, 32'h0001_0000, 16'h0000, 16'hFFFF);
		send_var(32'h0000_0003, 32'h0000_0000, 32'h0000_0001, 16'h0000, 16'h4000);
		send_var(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 16'h0000, 16'hC000);
		set_prob(16'h0000);
		send_var(32'h0005_0000, 32'h0000_0000, 32'h000A_0000, 16'h0000, 16'h0000);
		send_var(32'h0005_0000, 32'h0000_0000, 32'h000A_0000, 16'h0001, 16'hFFFF);
		send_var(32'h7FFF_FFFF, 32'h0000_0000, 32'h000A_0000, 16'hFFFF, 16'h1000);
		for (int ph = 0; ph < 20; ph++) begin
			set_prob((ph % 5 == 2) ? 16'($urandom) : probs[ph % 5]);
			case (ph % 4)
				0: begin src_idle = 0; snk_stall = 0; end
				1: begin src_idle = 49; snk_stall = 0; end
				2: begin src_idle = 0; snk_stall = 49; end
				default: begin src_idle = 7; snk_stall = 7; end
			endcase
			for (int n = 0; n < 70; n++)
				send_rand();
		end
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (n_pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (n_errors == 0)
			$display("polynomial_mutation_core_tb: done, clean");
		else
			$display("polynomial_mutation_core_tb: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
